FILE: rtl/okstq_pkg.sv
// shared types and constants for the owner-keyed sorted timer queue
`default_nettype none
package okstq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int MAX_POPS  = 32;
  localparam int OWNER_W   = 8;
  localparam int TIME_W    = 32;
  localparam int HANDLE_W  = 16;
  localparam int POP_W     = 6;
  localparam int STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REARMED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  localparam logic OP_ARM    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  typedef struct packed {
    logic    load;     // capture the request beat
    logic    idx_clr;
    logic    idx_inc;
    logic    keep;     // latch the handle of the matching entry
    logic    remove;   // close the gap at idx
    logic    insert;   // open a gap at idx and write the captured entry
    logic    pop;      // drop the head entry
    logic    emit;     // load the output register
    status_t code;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic owner_match;
    logic dl_greater;
    logic full;
    logic head_due;
    logic next_due;
    logic pops_max;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/okstq_req_if.sv
// request channel: arm and expire beats
`default_nettype none
interface okstq_req_if;
  import okstq_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [OWNER_W-1:0]  owner;
  logic [TIME_W-1:0]   deadline;
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   now;
  modport source (output valid, opcode, owner, deadline, handle, now, input ready);
  modport sink (input valid, opcode, owner, deadline, handle, now, output ready);
endinterface
`default_nettype wire

FILE: rtl/okstq_rsp_if.sv
// response channel: one beat per result
`default_nettype none
interface okstq_rsp_if;
  import okstq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OWNER_W-1:0]  owner_out;
  logic [HANDLE_W-1:0] handle_out;
  logic [POP_W-1:0]    pop_count;
  logic                last;
  modport source (output valid, status, owner_out, handle_out, pop_count, last,
                  input ready);
  modport sink (input valid, status, owner_out, handle_out, pop_count, last,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/okstq_ctrl.sv
// sequencer for owner search, removal, sorted insert and head pops
`default_nettype none
module okstq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_opcode,
  output logic           req_ready,
  input  okstq_pkg::stat_t st,
  output okstq_pkg::cmd_t  cmd
);
  import okstq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_REMOVE, S_FIND, S_INSERT, S_ARM_OUT, S_EXP
  } state_t;

  state_t  state, state_next;
  status_t arm_code, arm_code_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.code      = ST_NONE;
    state_next    = state;
    arm_code_next = arm_code;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = (req_opcode == OP_ARM) ? S_SCAN : S_EXP;
        end
      end
      S_SCAN: begin
        if (st.at_end) begin
          if (st.full) begin
            arm_code_next = ST_FULL;
            state_next    = S_ARM_OUT;
          end else begin
            arm_code_next = ST_INSERTED;
            cmd.idx_clr   = 1'b1;
            state_next    = S_FIND;
          end
        end else if (st.owner_match) begin
          arm_code_next = ST_REARMED;
          cmd.keep      = 1'b1;
          state_next    = S_REMOVE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_REMOVE: begin
        cmd.remove  = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = S_FIND;
      end
      S_FIND: begin
        if (st.at_end || st.dl_greater) state_next = S_INSERT;
        else cmd.idx_inc = 1'b1;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_ARM_OUT;
      end
      S_ARM_OUT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.code   = arm_code;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXP: begin
        if (st.out_free) begin
          if (st.head_due) begin
            cmd.pop  = 1'b1;
            cmd.emit = 1'b1;
            cmd.code = ST_EXPIRED;
            cmd.last = !(st.next_due && !st.pops_max);
            if (cmd.last) state_next = S_IDLE;
          end else begin
            // nothing due at entry
            cmd.emit   = 1'b1;
            cmd.code   = ST_NONE;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      arm_code <= ST_INSERTED;
    end else begin
      state    <= state_next;
      arm_code <= arm_code_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/okstq_dpath.sv
// entry store as a shift line, scan index, capture and output registers
`default_nettype none
module okstq_dpath #(
  parameter int DEPTH = okstq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [okstq_pkg::OWNER_W-1:0] req_owner,
  input  logic [okstq_pkg::TIME_W-1:0]  req_deadline,
  input  logic [okstq_pkg::HANDLE_W-1:0] req_handle,
  input  logic [okstq_pkg::TIME_W-1:0]  req_now,
  input  okstq_pkg::cmd_t               cmd,
  output okstq_pkg::stat_t              st,
  okstq_rsp_if.source                   rsp
);
  import okstq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [OWNER_W-1:0]  e_owner  [DEPTH];
  logic [TIME_W-1:0]   e_dl     [DEPTH];
  logic [HANDLE_W-1:0] e_handle [DEPTH];

  logic [CW-1:0]       count, idx, shl_pos;
  logic [IW-1:0]       ix;
  logic [OWNER_W-1:0]  cap_owner;
  logic [TIME_W-1:0]   cap_dl, cap_now;
  logic [HANDLE_W-1:0] cap_handle;
  logic [POP_W-1:0]    pops;
  logic                ovalid;

  assign ix      = idx[IW-1:0];
  assign shl_pos = cmd.pop ? '0 : idx;

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (CW'(g) == idx) begin
          e_owner[g]  <= cap_owner;
          e_dl[g]     <= cap_dl;
          e_handle[g] <= cap_handle;
        end else if (CW'(g) > idx) begin
          if (g > 0) begin
            e_owner[g]  <= e_owner[(g > 0) ? g - 1 : 0];
            e_dl[g]     <= e_dl[(g > 0) ? g - 1 : 0];
            e_handle[g] <= e_handle[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.remove || cmd.pop) begin
        if (g < DEPTH - 1 && CW'(g) >= shl_pos) begin
          e_owner[g]  <= e_owner[(g < DEPTH - 1) ? g + 1 : g];
          e_dl[g]     <= e_dl[(g < DEPTH - 1) ? g + 1 : g];
          e_handle[g] <= e_handle[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_owner  <= req_owner;
      cap_dl     <= req_deadline;
      cap_handle <= req_handle;
      cap_now    <= req_now;
    end else if (cmd.keep) begin
      cap_handle <= e_handle[ix];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      pops   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (cmd.idx_clr)     idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.insert)                   count <= count + 1'b1;
      else if (cmd.remove || cmd.pop)   count <= count - 1'b1;
      if (cmd.load)     pops <= '0;
      else if (cmd.pop) pops <= pops + 1'b1;
      if (cmd.emit)           ovalid <= 1'b1;
      else if (rsp.ready)     ovalid <= 1'b0;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status <= cmd.code;
      rsp.last   <= cmd.last;
      case (cmd.code)
        ST_EXPIRED: begin
          rsp.owner_out  <= e_owner[0];
          rsp.handle_out <= e_handle[0];
          rsp.pop_count  <= pops + 1'b1;
        end
        ST_NONE: begin
          rsp.owner_out  <= '0;
          rsp.handle_out <= '0;
          rsp.pop_count  <= '0;
        end
        default: begin
          rsp.owner_out  <= cap_owner;
          rsp.handle_out <= '0;
          rsp.pop_count  <= '0;
        end
      endcase
    end
  end

  assign rsp.valid = ovalid;

  assign st.at_end      = (idx == count);
  assign st.owner_match = (e_owner[ix] == cap_owner);
  assign st.dl_greater  = (e_dl[ix] > cap_dl);
  assign st.full        = (count == CW'(DEPTH));
  assign st.head_due    = (count != '0) && (e_dl[0] <= cap_now);
  assign st.next_due    = (count > CW'(1)) && (e_dl[1] <= cap_now);
  assign st.pops_max    = (pops == POP_W'(MAX_POPS - 1));
  assign st.out_free    = !ovalid || rsp.ready;

endmodule
`default_nettype wire

FILE: rtl/owner_keyed_sorted_timer_queue.sv
// arm: owner scan, a removal step on a re-arm, insert-place scan, an insert step, then the
// result beat once the output is free; a full queue with no owner match skips removal and insert and returns FULL.
// expire: one result beat per cycle per popped head entry while the sink is ready,
// at most MAX_POPS beats; the next request is taken after the last beat is loaded.
// synchronous active-high reset empties the queue; entry contents are not cleared.
`default_nettype none
module owner_keyed_sorted_timer_queue #(
  parameter int DEPTH = okstq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  okstq_req_if.sink   req,
  okstq_rsp_if.source rsp
);
  import okstq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  okstq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .st         (st),
    .cmd        (cmd)
  );

  okstq_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .req_owner    (req.owner),
    .req_deadline (req.deadline),
    .req_handle   (req.handle),
    .req_now      (req.now),
    .cmd          (cmd),
    .st           (st),
    .rsp          (rsp)
  );

endmodule
`default_nettype wire
